// ----- src/cpc_pkg.sv -----
// Shared types and constants for the climate cooler and pump controller.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned MARGIN_W = 10;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ON_MARGIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_ABSOLUTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_MARGIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_ABSOLUTE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_DURATION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_EXPIRY = 3'd6;

  // Reset values (tenths of a degree, milliseconds)
  localparam logic [MARGIN_W-1:0]      RST_ON_MARGIN     = 10'd5;
  localparam logic signed [TEMP_W-1:0] RST_ON_ABSOLUTE   = 12'sd350;
  localparam logic [MARGIN_W-1:0]      RST_OFF_MARGIN    = 10'd2;
  localparam logic signed [TEMP_W-1:0] RST_OFF_ABSOLUTE  = 12'sd330;
  localparam logic [MS_W-1:0]          RST_PUMP_INTERVAL = 32'd20000;
  localparam logic [MS_W-1:0]          RST_PUMP_DURATION = 32'd10000;
  localparam logic [MS_W-1:0]          RST_MANUAL_EXPIRY = 32'd60000;

  typedef struct packed {
    logic [MARGIN_W-1:0]      on_margin;
    logic signed [TEMP_W-1:0] on_absolute;
    logic [MARGIN_W-1:0]      off_margin;
    logic signed [TEMP_W-1:0] off_absolute;
    logic [MS_W-1:0]          pump_interval;
    logic [MS_W-1:0]          pump_duration;
    logic [MS_W-1:0]          manual_expiry;
  } cfg_t;

  typedef struct packed {
    logic [MS_W-1:0]          now_ms;
    logic signed [TEMP_W-1:0] temp_internal;
    logic signed [TEMP_W-1:0] temp_external;
    logic                     soil_dry;
    logic                     manual_request;
    logic                     manual_value;
  } tick_t;

  // Per-tick decisions from the control stage
  typedef struct packed {
    logic cooler_run;
    logic pump_on;
    logic led_on;
    logic override_active;
  } decision_t;

endpackage

`default_nettype wire

// ----- src/cpc_ifs.sv -----
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on cpc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cpc_in_if;
  import cpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MS_W-1:0]          now_ms;
  logic signed [TEMP_W-1:0] temp_internal;
  logic signed [TEMP_W-1:0] temp_external;
  logic                     soil_dry;
  logic                     manual_request;
  logic                     manual_value;

  modport source (output valid, now_ms, temp_internal, temp_external, soil_dry,
                  manual_request, manual_value, input ready);
  modport sink (input valid, now_ms, temp_internal, temp_external, soil_dry,
                manual_request, manual_value, output ready);
endinterface

interface cpc_out_if;
  logic valid;
  logic ready;
  logic cooler_run;
  logic pump_on;
  logic led_on;
  logic buzzer_on;
  logic override_active;

  modport source (output valid, cooler_run, pump_on, led_on, buzzer_on,
                  override_active, input ready);
  modport sink (input valid, cooler_run, pump_on, led_on, buzzer_on,
                override_active, output ready);
endinterface

`default_nettype wire

// ----- src/climate_cooler_pump_controller_core.sv -----
// Top level of the climate cooler and pump controller: input register,
// control/blink stage, result register. Depends on cpc_pkg, cpc_ifs,
// cpc_regs, cpc_ctrl and cpc_blink.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_ch    | in  | valid/ready       | now_ms, temp_internal, temp_external,
//            |     |                   | soil_dry, manual_request, manual_value
//   out_ch   | out | valid/ready       | cooler_run, pump_on, led_on, buzzer_on,
//            |     |                   | override_active
//   cfg      | in  | cfg_we, no ready  | cfg_index, cfg_data
//
// Each tick passes three registers (input, product, result) before it leaves on
// out_ch; one tick is accepted per cycle while out_ch does not stall the pipe.
// The blink reciprocal multiplier sets the middle stage.
// Synchronous active-high reset clears all stage valids, controller state and
// configuration. A stall on out_ch backs up stage by stage; in_ch.ready drops
// only when all three registers hold ticks.
`timescale 1ns / 1ps
`default_nettype none

module climate_cooler_pump_controller_core #(
  parameter int unsigned BLINK_HALF_MS = 500,
  parameter int unsigned TIME_BITS     = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  cpc_in_if.sink                                 in_ch,
  cpc_out_if.source                              out_ch
);
  import cpc_pkg::*;

  cfg_t      cfg;
  tick_t     tick;
  decision_t decision, decision_hold;
  logic      v0, v1, v2;
  logic      adv0, adv1, adv2;
  logic      in_take;
  logic      phase_even;

  cpc_regs u_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Stage transfers: a stage loads when it is empty or its occupant moves on
  assign adv2    = v2 && out_ch.ready;
  assign adv1    = v1 && (!v2 || adv2);
  assign adv0    = v0 && (!v1 || adv1);
  assign in_ch.ready = !v0 || adv0;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (in_take) begin
        v0 <= 1'b1;
      end else if (adv0) begin
        v0 <= 1'b0;
      end
      if (adv0) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick.now_ms         <= in_ch.now_ms;
      tick.temp_internal  <= in_ch.temp_internal;
      tick.temp_external  <= in_ch.temp_external;
      tick.soil_dry       <= in_ch.soil_dry;
      tick.manual_request <= in_ch.manual_request;
      tick.manual_value   <= in_ch.manual_value;
    end
  end

  // Controller state advances as each tick leaves the input register
  cpc_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (adv0),
    .tick     (tick),
    .cfg      (cfg),
    .decision (decision)
  );

  cpc_blink #(
    .BLINK_HALF_MS (BLINK_HALF_MS),
    .TIME_BITS     (TIME_BITS)
  ) u_blink (
    .clk        (clk),
    .load       (adv0),
    .now_ms     (tick.now_ms),
    .phase_even (phase_even)
  );

  always_ff @(posedge clk) begin
    if (adv0) begin
      decision_hold <= decision;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_ch.cooler_run      <= decision_hold.cooler_run;
      out_ch.pump_on         <= decision_hold.pump_on;
      out_ch.led_on          <= decision_hold.led_on;
      out_ch.buzzer_on       <= decision_hold.led_on && phase_even && !decision_hold.pump_on;
      out_ch.override_active <= decision_hold.override_active;
    end
  end

  assign out_ch.valid = v2;

  a_ready_when_input_empty: assert property (@(posedge clk) disable iff (rst)
    !v0 |-> in_ch.ready)
    else $error("input not ready with empty input register");

  a_advance_fills_middle: assert property (@(posedge clk) disable iff (rst)
    adv0 |=> v1)
    else $error("tick lost between input and middle stage");

  a_buzzer_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.buzzer_on) |-> (out_ch.led_on && !out_ch.pump_on))
    else $error("buzzer on with wet soil or running pump");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- src/cpc_regs.sv -----
// Configuration register file, written through a plain write port.
// Depends on cpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpc_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              we,
  input  wire logic [cpc_pkg::CFG_IDX_W-1:0]     index,
  input  wire logic [cpc_pkg::CFG_DATA_W-1:0]    data,
  output cpc_pkg::cfg_t                          cfg
);
  import cpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_margin     <= RST_ON_MARGIN;
      cfg.on_absolute   <= RST_ON_ABSOLUTE;
      cfg.off_margin    <= RST_OFF_MARGIN;
      cfg.off_absolute  <= RST_OFF_ABSOLUTE;
      cfg.pump_interval <= RST_PUMP_INTERVAL;
      cfg.pump_duration <= RST_PUMP_DURATION;
      cfg.manual_expiry <= RST_MANUAL_EXPIRY;
    end else if (we) begin
      case (index)
        REG_ON_MARGIN:     cfg.on_margin     <= data[MARGIN_W-1:0];
        REG_ON_ABSOLUTE:   cfg.on_absolute   <= $signed(data[TEMP_W-1:0]);
        REG_OFF_MARGIN:    cfg.off_margin    <= data[MARGIN_W-1:0];
        REG_OFF_ABSOLUTE:  cfg.off_absolute  <= $signed(data[TEMP_W-1:0]);
        REG_PUMP_INTERVAL: cfg.pump_interval <= data[MS_W-1:0];
        REG_PUMP_DURATION: cfg.pump_duration <= data[MS_W-1:0];
        REG_MANUAL_EXPIRY: cfg.manual_expiry <= data[MS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/cpc_ctrl.sv -----
// Control stage: cooler hysteresis, manual override and automatic watering.
// Holds the controller state; depends on cpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpc_ctrl #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire cpc_pkg::tick_t tick,
  input  wire cpc_pkg::cfg_t  cfg,
  output cpc_pkg::decision_t  decision
);
  import cpc_pkg::*;

  // Compare width covers both the time word and the 32-bit thresholds
  localparam int unsigned CW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

  logic                 cooler_state, cooler_state_next;
  logic                 auto_watering, auto_watering_next;
  logic [TIME_BITS-1:0] watering_start, watering_start_next;
  logic                 override_flag, override_flag_next;
  logic                 override_level, override_level_next;
  logic [TIME_BITS-1:0] override_time, override_time_next;

  logic [CW-1:0]           now_wide;
  logic [TIME_BITS-1:0]    now_t;
  logic [TIME_BITS-1:0]    since_override, since_watering;
  logic signed [TEMP_W:0]  diff;
  logic                    turn_on, turn_off;
  logic                    override_lapsed, start_watering, watering_done, watering_on;

  always_comb begin
    now_wide = CW'(tick.now_ms);
    now_t    = now_wide[TIME_BITS-1:0];

    diff     = {tick.temp_internal[TEMP_W-1], tick.temp_internal}
             - {tick.temp_external[TEMP_W-1], tick.temp_external};
    turn_on  = (diff >= $signed({3'b000, cfg.on_margin}))
            || (tick.temp_internal >= cfg.on_absolute);
    turn_off = (diff < $signed({3'b000, cfg.off_margin}))
            && (tick.temp_internal < cfg.off_absolute);
    cooler_state_next = cooler_state ? !turn_off : turn_on;

    // A fresh command restamps the override, so its elapsed time is zero
    since_override      = now_t - override_time;
    override_level_next = tick.manual_request ? tick.manual_value : override_level;
    override_time_next  = tick.manual_request ? now_t : override_time;
    override_lapsed     = tick.manual_request ? (cfg.manual_expiry == '0)
                        : (CW'(since_override) >= CW'(cfg.manual_expiry));
    override_flag_next  = (tick.manual_request || override_flag) && !override_lapsed;

    since_watering      = now_t - watering_start;
    start_watering      = !auto_watering
                        && (CW'(since_watering) >= CW'(cfg.pump_interval));
    watering_start_next = start_watering ? now_t : watering_start;
    watering_done       = start_watering ? (cfg.pump_duration == '0)
                        : (CW'(since_watering) >= CW'(cfg.pump_duration));
    watering_on         = start_watering || auto_watering;
    auto_watering_next  = watering_on && !watering_done;

    decision.cooler_run      = cooler_state_next;
    decision.pump_on         = override_flag_next ? override_level_next : auto_watering_next;
    decision.led_on          = tick.soil_dry;
    decision.override_active = override_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooler_state   <= 1'b0;
      auto_watering  <= 1'b0;
      watering_start <= '0;
      override_flag  <= 1'b0;
      override_level <= 1'b0;
      override_time  <= '0;
    end else if (step) begin
      cooler_state   <= cooler_state_next;
      auto_watering  <= auto_watering_next;
      watering_start <= watering_start_next;
      override_flag  <= override_flag_next;
      override_level <= override_level_next;
      override_time  <= override_time_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cpc_blink.sv -----
// Blink phase: parity of now / BLINK_HALF_MS by reciprocal multiply,
// registered product, then a single correction step. Depends on cpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpc_blink #(
  parameter int unsigned BLINK_HALF_MS = 500,
  parameter int unsigned TIME_BITS     = 32
) (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic [cpc_pkg::MS_W-1:0]  now_ms,
  output logic                           phase_even
);
  import cpc_pkg::*;

  // q_est = (x * RECIP) >> SHIFT is the true quotient or one below it
  localparam int unsigned SHIFT = 31 + $clog2(BLINK_HALF_MS);
  localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(BLINK_HALF_MS);
  localparam logic [MS_W-1:0] RECIP = RECIP_WIDE[MS_W-1:0];
  localparam logic [MS_W-1:0] DIVISOR = MS_W'(BLINK_HALF_MS);
  localparam logic [63:0] NOW_MASK_WIDE = (TIME_BITS >= MS_W) ? 64'hFFFF_FFFF
                                        : ((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [MS_W-1:0] NOW_MASK = NOW_MASK_WIDE[MS_W-1:0];

  logic [MS_W-1:0]   x_in;
  logic [2*MS_W-1:0] product;
  logic [MS_W-1:0]   x_hold;
  logic [MS_W-1:0]   q_est;
  logic [MS_W-1:0]   remainder;
  logic              q_odd;

  assign x_in    = now_ms & NOW_MASK;
  assign product = {{MS_W{1'b0}}, x_in} * {{MS_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (load) begin
      x_hold <= x_in;
      q_est  <= MS_W'(product >> SHIFT);
    end
  end

  always_comb begin
    remainder  = x_hold - MS_W'(q_est * DIVISOR);
    // Remainder at or above the divisor means the estimate was one short
    q_odd      = q_est[0] ^ (remainder >= DIVISOR);
    phase_even = !q_odd;
  end

endmodule

`default_nettype wire

// ----- dv/tb_climate_cooler_pump_controller_core.sv -----
// Self-checking testbench for climate_cooler_pump_controller_core: directed and random ticks,
// register settings per phase, random idling on both channels, in-order result checks.
// Depends on cpc_pkg, cpc_ifs and the RTL of the core.
`timescale 1ns / 1ps

module tb_climate_cooler_pump_controller_core;
  import cpc_pkg::*;

  localparam int unsigned BLINK_HALF_MS = 500;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned PHASE_TICKS   = 125;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic cooler_run;
    logic pump_on;
    logic led_on;
    logic buzzer_on;
    logic override_active;
  } outputs_t;

  class cooler_pump_tracker;
    cfg_t            settings;
    bit              cooler, watering, manual_hold, manual_level;
    logic [MS_W-1:0] water_start_ms, manual_stamp_ms;
    outputs_t        expected_q[$];
    int unsigned     errors;

    function new();
      settings.on_margin     = RST_ON_MARGIN;
      settings.on_absolute   = RST_ON_ABSOLUTE;
      settings.off_margin    = RST_OFF_MARGIN;
      settings.off_absolute  = RST_OFF_ABSOLUTE;
      settings.pump_interval = RST_PUMP_INTERVAL;
      settings.pump_duration = RST_PUMP_DURATION;
      settings.manual_expiry = RST_MANUAL_EXPIRY;
      cooler          = 1'b0;
      watering        = 1'b0;
      manual_hold     = 1'b0;
      manual_level    = 1'b0;
      water_start_ms  = '0;
      manual_stamp_ms = '0;
      errors          = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_ON_MARGIN:     settings.on_margin     = data[MARGIN_W-1:0];
        REG_ON_ABSOLUTE:   settings.on_absolute   = data[TEMP_W-1:0];
        REG_OFF_MARGIN:    settings.off_margin    = data[MARGIN_W-1:0];
        REG_OFF_ABSOLUTE:  settings.off_absolute  = data[TEMP_W-1:0];
        REG_PUMP_INTERVAL: settings.pump_interval = data[MS_W-1:0];
        REG_PUMP_DURATION: settings.pump_duration = data[MS_W-1:0];
        REG_MANUAL_EXPIRY: settings.manual_expiry = data[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function void record_tick(tick_t t);
      int              t_in, margin;
      logic [MS_W-1:0] since;
      outputs_t        predicted;
      t_in   = int'($signed(t.temp_internal));
      margin = t_in - int'($signed(t.temp_external));

      if (!cooler)
        cooler = (margin >= int'(settings.on_margin)) ||
                 (t_in >= int'($signed(settings.on_absolute)));
      else
        cooler = !((margin < int'(settings.off_margin)) &&
                   (t_in < int'($signed(settings.off_absolute))));

      // A new command restamps the override before the expiry check
      if (t.manual_request) begin
        manual_hold     = 1'b1;
        manual_level    = t.manual_value;
        manual_stamp_ms = t.now_ms;
      end
      since = t.now_ms - manual_stamp_ms;
      if (manual_hold && since >= settings.manual_expiry)
        manual_hold = 1'b0;

      since = t.now_ms - water_start_ms;
      if (!watering && since >= settings.pump_interval) begin
        watering       = 1'b1;
        water_start_ms = t.now_ms;
      end
      since = t.now_ms - water_start_ms;
      if (watering && since >= settings.pump_duration)
        watering = 1'b0;

      predicted.cooler_run      = cooler;
      predicted.pump_on         = manual_hold ? manual_level : watering;
      predicted.led_on          = t.soil_dry;
      predicted.buzzer_on       = t.soil_dry && ((t.now_ms / BLINK_HALF_MS) % 2 == 0) &&
                                  !predicted.pump_on;
      predicted.override_active = manual_hold;
      expected_q.push_back(predicted);
    endfunction

    function void check_outputs(outputs_t got);
      outputs_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result %b (cooler pump led buzzer override)", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: expected %b, got %b (cooler pump led buzzer override)",
                     want, got);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           stall_pct;
  int unsigned           quiet_cycles = 0;
  logic [MS_W-1:0]       clock_ms;
  cooler_pump_tracker    tracker;

  cpc_in_if  in_ch();
  cpc_out_if out_ch();

  climate_cooler_pump_controller_core #(
    .BLINK_HALF_MS(BLINK_HALF_MS),
    .TIME_BITS(MS_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      tracker.check_outputs({out_ch.cooler_run, out_ch.pump_on, out_ch.led_on,
                             out_ch.buzzer_on, out_ch.override_active});
  end

  // Stop a hung run: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("climate_cooler_pump_controller_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tick_t mk_tick(logic [MS_W-1:0] now, int ti, int te,
                                    bit dry, bit req, bit lvl);
    tick_t t;
    t.now_ms         = now;
    t.temp_internal  = ti[TEMP_W-1:0];
    t.temp_external  = te[TEMP_W-1:0];
    t.soil_dry       = dry;
    t.manual_request = req;
    t.manual_value   = lvl;
    return t;
  endfunction

  task automatic send_tick(input tick_t t, input int unsigned gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.now_ms         <= t.now_ms;
    in_ch.temp_internal  <= t.temp_internal;
    in_ch.temp_external  <= t.temp_external;
    in_ch.soil_dry       <= t.soil_dry;
    in_ch.manual_request <= t.manual_request;
    in_ch.manual_value   <= t.manual_value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.record_tick(t);
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(index, data);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] on_m, on_a, off_m, off_a,
                                input logic [CFG_DATA_W-1:0] interval, duration, expiry);
    write_reg(REG_ON_MARGIN, on_m);
    write_reg(REG_ON_ABSOLUTE, on_a);
    write_reg(REG_OFF_MARGIN, off_m);
    write_reg(REG_OFF_ABSOLUTE, off_a);
    write_reg(REG_PUMP_INTERVAL, interval);
    write_reg(REG_PUMP_DURATION, duration);
    write_reg(REG_MANUAL_EXPIRY, expiry);
    write_reg(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count, gap_pct, stall,
                           input logic [MS_W-1:0] start_ms, input int unsigned max_step);
    int ti, te, d;
    stall_pct <= stall;
    clock_ms = start_ms;
    repeat (count) begin
      // Mostly advancing time, now and then a jump anywhere
      if ($urandom_range(24) == 0)
        clock_ms = $urandom();
      else
        clock_ms = clock_ms + $urandom_range(max_step);
      te = int'($urandom_range(2050)) - 550;
      d  = int'($urandom_range(6)) - 3;
      case ($urandom_range(9))
        0: begin
          ti = int'($urandom_range(4095)) - 2048;
          te = int'($urandom_range(4095)) - 2048;
        end
        1:       ti = int'($signed(tracker.settings.on_absolute)) + d;
        2:       ti = int'($signed(tracker.settings.off_absolute)) + d;
        3, 4:    ti = te + int'(tracker.settings.on_margin) + d;
        5, 6:    ti = te + int'(tracker.settings.off_margin) + d;
        default: ti = te + 5 * d;
      endcase
      if ($urandom_range(149) == 0)
        drain_results();
      send_tick(mk_tick(clock_ms, ti, te, $urandom_range(1), $urandom_range(7) == 0,
                        $urandom_range(1)), gap_pct);
    end
    drain_results();
  endtask

  initial begin
    int unsigned mode, gap, stall;
    tracker              = new();
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.now_ms         = '0;
    in_ch.temp_internal  = '0;
    in_ch.temp_external  = '0;
    in_ch.soil_dry       = 1'b0;
    in_ch.manual_request = 1'b0;
    in_ch.manual_value   = 1'b0;
    out_ch.ready         = 1'b0;
    stall_pct            = 0;
    clock_ms             = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: thresholds at equality, first watering, override, time wrap
    send_tick(mk_tick(32'd0, 0, 0, 1'b0, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd100, 2047, -2048, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd600, -2048, 2047, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd1000, 350, 400, 1'b0, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd1500, 329, 328, 1'b0, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd2000, 305, 300, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd2500, 330, 330, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd3000, 300, 298, 1'b0, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd3500, 300, 299, 1'b0, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd19999, 200, 100, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd20000, 200, 100, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd29999, 200, 100, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd30000, -550, 1500, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd31000, 1500, -550, 1'b0, 1'b1, 1'b1), 0);
    send_tick(mk_tick(32'd40000, 0, 0, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd45000, 0, 0, 1'b1, 1'b1, 1'b0), 0);
    send_tick(mk_tick(32'd104999, 0, 0, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'd105000, 0, 0, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'hFFFF_FE00, 0, 0, 1'b1, 1'b1, 1'b1), 0);
    send_tick(mk_tick(32'h0000_EA00, 0, 0, 1'b1, 1'b0, 1'b0), 0);
    drain_results();

    // Zero expiry, interval and duration: override and watering end on their own tick
    apply_settings(RST_ON_MARGIN, RST_ON_ABSOLUTE, RST_OFF_MARGIN, RST_OFF_ABSOLUTE,
                   32'd0, 32'd0, 32'd0);
    send_tick(mk_tick(32'd5000, 0, 0, 1'b1, 1'b1, 1'b1), 0);
    send_tick(mk_tick(32'd5001, 0, 0, 1'b1, 1'b0, 1'b0), 0);
    send_tick(mk_tick(32'hFFFF_FFFF, 2047, 2047, 1'b1, 1'b1, 1'b0), 0);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      mode  = phase % 4;
      gap   = (mode == 1) ? 78 : (mode == 3) ? 7 : 0;
      stall = (mode == 2) ? 78 : (mode == 3) ? 7 : 0;
      case (phase)
        0: begin
          apply_settings(32'd5, 32'd350, 32'd2, 32'd330, 32'd3000, 32'd1500, 32'd4000);
          run_phase(PHASE_TICKS, gap, stall, 32'd0, 1000);
        end
        1: begin
          apply_settings(32'd0, 32'h800, 32'd1023, 32'h7FF, 32'd0, 32'd0, 32'd0);
          run_phase(PHASE_TICKS, gap, stall, $urandom(), 1000);
        end
        2: begin
          apply_settings(32'd1023, 32'h7FF, 32'd0, 32'h800,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          run_phase(PHASE_TICKS, gap, stall, 32'hFFFF_F000, 1000);
        end
        3: begin
          apply_settings(32'd30, 32'd250, 32'd10, 32'hFFFF_FF9C, 32'd1000, 32'd800, 32'd1500);
          run_phase(PHASE_TICKS, gap, stall, 32'hFFFF_E000, 600);
        end
        4: begin
          // Upper data bits beyond each register width are dropped
          apply_settings(32'hFFFF_FC05, 32'hFFFF_F15E, 32'hABCD_0002, 32'h1234_514A,
                         32'd0, 32'd2000, 32'd500);
          run_phase(PHASE_TICKS, gap, stall, $urandom(), 500);
        end
        default: begin
          apply_settings(32'd100, 32'd600, 32'd50, 32'd400, 32'd5000, 32'd0, 32'd2500);
          run_phase(PHASE_TICKS, gap, stall, $urandom(), 900);
        end
      endcase
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0)
      $display("climate_cooler_pump_controller_core test passed");
    else
      $display("climate_cooler_pump_controller_core test failed");
    $finish;
  end

endmodule
